@@ src/pts_pkg.sv @@
// Package for the periodic timer slot pool.
// Holds the request/response types, command and status codes, and the
// sequencer state type. No dependencies.
package pts_pkg;

  localparam int TIMERS = 16;
  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W = 18;
  localparam int SLOT_W = 4;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int INTERVAL_W = 24;
  localparam int TAG_W = 32;
  localparam int CLOSE_W = 8;

  localparam logic [INTERVAL_W-1:0] BASE_MS = INTERVAL_W'(100);

  // floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for every 24-bit x
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W = 25;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(21474837);
  localparam int PROD_W = INTERVAL_W + RECIP_W;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_CREATED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [INTERVAL_W-1:0] interval_ms;
    logic [TAG_W-1:0]      user_tag;
    logic [CLOSE_W-1:0]    close_slot;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_id;
    logic [TAG_W-1:0]    tag_out;
    logic                last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ALLOC,
    S_TICK,
    S_FLUSH
  } state_t;

endpackage

@@ src/pts_req_if.sv @@
// Request channel of the periodic timer slot pool.
// Valid/ready handshake carrying pts_pkg::req_t; depends on pts_pkg.
interface pts_req_if;
  logic          valid;
  logic          ready;
  pts_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/pts_rsp_if.sv @@
// Response channel of the periodic timer slot pool.
// Valid/ready handshake carrying pts_pkg::rsp_t; depends on pts_pkg.
interface pts_rsp_if;
  logic          valid;
  logic          ready;
  pts_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/periodic_timer_slot_pool_top.sv @@
// Top level of the periodic timer slot pool: sequencer, slot store and
// response register. Depends on pts_pkg, pts_req_if and pts_rsp_if.
//
// Requests are taken one at a time. A close gives no response. A create
// with an interval under 100 ms goes straight to the flush state; any
// other create first does the reciprocal multiply, then visits slots in
// ascending order, one per cycle, until it finds a free one or reaches the
// last slot, then hands over its single response. A tick visits all 16
// slots, one per cycle while no earlier expiry waits on a stalled response
// side, through one shared increment and compare unit, then hands over the
// final expiry. The response register lets the next request in while a
// response waits.
module periodic_timer_slot_pool_top (
  input logic      clk,
  input logic      rst,
  pts_req_if.sink  req,
  pts_rsp_if.source rsp
);

  pts_pkg::state_t state;
  pts_pkg::state_t state_next;

  logic [pts_pkg::IDX_W-1:0]      idx;
  pts_pkg::req_t                  req_q;
  logic [pts_pkg::PROD_W-1:0]     prod;
  logic                           pend_valid;
  pts_pkg::rsp_t                  pend;
  logic                           out_valid;
  pts_pkg::rsp_t                  out_q;

  logic [pts_pkg::TIMERS-1:0]     slot_open;
  logic [pts_pkg::CNT_W-1:0]      reload_ticks [pts_pkg::TIMERS];
  logic [pts_pkg::CNT_W-1:0]      tick_count [pts_pkg::TIMERS];
  logic [pts_pkg::TAG_W-1:0]      slot_tag [pts_pkg::TIMERS];

  logic                           accept;
  logic                           out_free;
  logic                           idx_last;
  logic [pts_pkg::CNT_W-1:0]      cnt_inc;
  logic                           exp_hit;
  logic                           advance;
  logic                           push_out;
  pts_pkg::rsp_t                  out_d;
  logic                           close_hit;
  logic                           alloc_hit;
  logic [pts_pkg::CNT_W-1:0]      quotient;

  assign req.ready = (state == pts_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign idx_last  = (idx == pts_pkg::IDX_W'(pts_pkg::TIMERS - 1));
  assign cnt_inc   = tick_count[idx] + pts_pkg::CNT_W'(1);
  assign quotient  = prod[pts_pkg::RECIP_SHIFT +: pts_pkg::CNT_W];
  assign close_hit = req.data.close_slot < pts_pkg::CLOSE_W'(pts_pkg::TIMERS);
  assign alloc_hit = (state == pts_pkg::S_ALLOC) && !slot_open[idx];

  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  always_comb begin
    state_next = state;
    case (state)
      pts_pkg::S_IDLE: begin
        if (accept) begin
          case (req.data.cmd)
            pts_pkg::CMD_CREATE: begin
              if (req.data.interval_ms < pts_pkg::BASE_MS) begin
                state_next = pts_pkg::S_FLUSH;
              end else begin
                state_next = pts_pkg::S_DIV;
              end
            end
            pts_pkg::CMD_TICK: state_next = pts_pkg::S_TICK;
            default: state_next = pts_pkg::S_IDLE;
          endcase
        end
      end
      pts_pkg::S_DIV: state_next = pts_pkg::S_ALLOC;
      pts_pkg::S_ALLOC: begin
        if (alloc_hit || idx_last) begin
          state_next = pts_pkg::S_FLUSH;
        end
      end
      pts_pkg::S_TICK: begin
        if (advance && idx_last) begin
          state_next = pts_pkg::S_FLUSH;
        end
      end
      pts_pkg::S_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = pts_pkg::S_IDLE;
        end
      end
      default: state_next = pts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    exp_hit  = 1'b0;
    advance  = 1'b1;
    push_out = 1'b0;
    out_d    = pend;
    case (state)
      pts_pkg::S_TICK: begin
        exp_hit  = slot_open[idx] && (cnt_inc >= reload_ticks[idx]);
        advance  = !(exp_hit && pend_valid && !out_free);
        push_out = exp_hit && pend_valid && out_free;
        out_d.last = 1'b0;
      end
      pts_pkg::S_FLUSH: begin
        push_out   = pend_valid && out_free;
        out_d.last = 1'b1;
      end
      default: begin
        push_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pts_pkg::S_IDLE;
      idx        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      slot_open  <= '0;
    end else begin
      state <= state_next;

      if (push_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        pts_pkg::S_IDLE: begin
          idx <= '0;
          if (accept) begin
            if (req.data.cmd == pts_pkg::CMD_CLOSE && close_hit) begin
              slot_open[req.data.close_slot[pts_pkg::IDX_W-1:0]] <= 1'b0;
            end
            if (req.data.cmd == pts_pkg::CMD_CREATE &&
                req.data.interval_ms < pts_pkg::BASE_MS) begin
              pend_valid <= 1'b1;
            end
          end
        end
        pts_pkg::S_ALLOC: begin
          if (alloc_hit) begin
            slot_open[idx] <= 1'b1;
            pend_valid     <= 1'b1;
          end else if (idx_last) begin
            pend_valid <= 1'b1;
          end else begin
            idx <= idx + pts_pkg::IDX_W'(1);
          end
        end
        pts_pkg::S_TICK: begin
          if (advance) begin
            if (exp_hit) begin
              pend_valid <= 1'b1;
            end
            if (!idx_last) begin
              idx <= idx + pts_pkg::IDX_W'(1);
            end
          end
        end
        pts_pkg::S_FLUSH: begin
          if (push_out) begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
          idx <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      out_q <= out_d;
    end
    if (accept) begin
      req_q <= req.data;
    end
    if (state == pts_pkg::S_DIV) begin
      prod <= pts_pkg::PROD_W'(req_q.interval_ms) * pts_pkg::PROD_W'(pts_pkg::RECIP);
    end
    case (state)
      pts_pkg::S_IDLE: begin
        pend.status  <= pts_pkg::ST_TOO_SHORT;
        pend.slot_id <= '0;
        pend.tag_out <= '0;
        pend.last    <= 1'b1;
      end
      pts_pkg::S_ALLOC: begin
        if (alloc_hit) begin
          reload_ticks[idx] <= quotient;
          tick_count[idx]   <= '0;
          slot_tag[idx]     <= req_q.user_tag;
          pend.status  <= pts_pkg::ST_CREATED;
          pend.slot_id <= pts_pkg::SLOT_W'(idx);
          pend.tag_out <= '0;
          pend.last    <= 1'b1;
        end else if (idx_last) begin
          pend.status  <= pts_pkg::ST_POOL_FULL;
          pend.slot_id <= '0;
          pend.tag_out <= '0;
          pend.last    <= 1'b1;
        end
      end
      pts_pkg::S_TICK: begin
        if (advance && slot_open[idx]) begin
          if (exp_hit) begin
            tick_count[idx] <= '0;
            pend.status  <= pts_pkg::ST_EXPIRED;
            pend.slot_id <= pts_pkg::SLOT_W'(idx);
            pend.tag_out <= slot_tag[idx];
            pend.last    <= 1'b0;
          end else begin
            tick_count[idx] <= cnt_inc;
          end
        end
      end
      default: begin
        pend.last <= pend.last;
      end
    endcase
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == pts_pkg::S_IDLE |-> !pend_valid)
    else $error("pending response left over in idle");

  a_alloc_opens_one: assert property (@(posedge clk) disable iff (rst)
    alloc_hit |=> $countones(slot_open) == $past($countones(slot_open)) + 1)
    else $error("allocation did not open exactly one slot");

  a_flush_marks_last: assert property (@(posedge clk) disable iff (rst)
    (state == pts_pkg::S_FLUSH && push_out) |=> out_valid && out_q.last)
    else $error("final response not marked last");

  a_tick_push_not_last: assert property (@(posedge clk) disable iff (rst)
    (state == pts_pkg::S_TICK && push_out) |=> out_valid && !out_q.last &&
    out_q.status == pts_pkg::ST_EXPIRED)
    else $error("mid-walk expiry response malformed");

endmodule
